[sv/wsrac_pkg.sv]
`timescale 1ns / 1ps
package wsrac_pkg;

  // table geometry
  localparam int ENTRIES = 16;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  localparam logic [15:0] HITS_MAX = 16'hFFFF;

  // direction codes
  localparam logic [1:0] DIR_FROM_STA = 2'd1;
  localparam logic [1:0] DIR_TO_STA   = 2'd2;

  // frame-control codes
  localparam logic [1:0] TYPE_MGMT      = 2'd0;
  localparam logic [3:0] SUB_PROBE_REQ  = 4'd4;
  localparam logic [3:0] SUB_PROBE_RESP = 4'd5;

  // configuration register indexes
  localparam logic [2:0] CFG_MAX_AGE    = 3'd0;
  localparam logic [2:0] CFG_TICK_STEP  = 3'd1;
  localparam logic [2:0] CFG_FILT_BCAST = 3'd2;
  localparam logic [2:0] CFG_OWN_PREFIX = 3'd3;
  localparam logic [2:0] CFG_PREFIX_LEN = 3'd4;

  typedef struct packed {
    logic [31:0] max_age;
    logic [15:0] tick_step;
    logic        filt_bcast;
    logic [47:0] own_prefix;
    logic [2:0]  own_prefix_len;
  } cfg_t;

  // classified work item passed from front to back
  typedef struct packed {
    logic              is_tick;
    logic [47:0]       station;
    logic [1:0]        dir;
    logic signed [7:0] sig;
  } job_t;

  typedef struct packed {
    logic signed [7:0] avg;
    logic signed [7:0] high;
    logic signed [7:0] low;
    logic [15:0]       count;
    logic [31:0]       age;
    logic [1:0]        dir;
    logic [47:0]       station;
  } report_t;

endpackage

[sv/wifi_station_rssi_aggregation_cache.sv]
`timescale 1ns / 1ps
// A tick only advances the clock in the back end; a frame walks all 16 slots one per cycle
// (pausing for each aged entry that it reports), then folds into an entry or inserts one; each reported
// entry waits on the 24-step serial divider and is staged as a report, and output stalls hold the walk.
// Dropped frames cost nothing downstream. A 2-entry queue lets input keep flowing while the back
// end works.
// Reset (synchronous) empties the table, zeroes the clock and loads the register defaults.
module wifi_station_rssi_aggregation_cache (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // frame_ctrl_low, frame_ctrl_high, address_one, address_two, address_three, signal_dbm
  input  logic [167:0] s_tdata,
  // opcode
  input  logic         s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // station_addr, direction, age_ms, frame_count, signal_min, signal_max, signal_avg, pad
  output logic [127:0] m_tdata,
  output logic         m_tlast,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [47:0]  cfg_data
);

  wsrac_pkg::cfg_t      cfg;
  wsrac_pkg::job_t      job;
  wsrac_pkg::report_t   rep;
  logic                 job_valid;
  logic                 job_ready;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_age        <= 32'd10000;
      cfg.tick_step      <= 16'd100;
      cfg.filt_bcast     <= 1'b1;
      cfg.own_prefix     <= '0;
      cfg.own_prefix_len <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        wsrac_pkg::CFG_MAX_AGE:    cfg.max_age        <= cfg_data[31:0];
        wsrac_pkg::CFG_TICK_STEP:  cfg.tick_step      <= cfg_data[15:0];
        wsrac_pkg::CFG_FILT_BCAST: cfg.filt_bcast     <= cfg_data[0];
        wsrac_pkg::CFG_OWN_PREFIX: cfg.own_prefix     <= cfg_data;
        wsrac_pkg::CFG_PREFIX_LEN: cfg.own_prefix_len <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  wsrac_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .job_valid (job_valid),
    .job_ready (job_ready),
    .job       (job)
  );

  wsrac_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .job_valid (job_valid),
    .job_ready (job_ready),
    .job       (job),
    .m_valid   (m_tvalid),
    .m_ready   (m_tready),
    .m_rep     (rep),
    .m_last    (m_tlast)
  );

  assign m_tdata = {6'd0, rep.avg, rep.high, rep.low, rep.count, rep.age, rep.dir, rep.station};

endmodule

[sv/wsrac_front.sv]
`timescale 1ns / 1ps
module wsrac_front (
  input  logic              clk,
  input  logic              rst,
  input  wsrac_pkg::cfg_t   cfg,
  input  logic              s_tvalid,
  output logic              s_tready,
  // frame_ctrl_low, frame_ctrl_high, address_one, address_two, address_three, signal_dbm
  input  logic [167:0]      s_tdata,
  // opcode
  input  logic              s_tuser,
  output logic              job_valid,
  input  logic              job_ready,
  output wsrac_pkg::job_t   job
);

  logic [7:0]        fcl;
  logic [7:0]        fch;
  logic [47:0]       a1;
  logic [47:0]       a2;
  logic [1:0]        ftype;
  logic [3:0]        fsub;
  logic              classed;
  logic              keep;
  wsrac_pkg::job_t   item;
  logic              push;
  logic              pop;

  wsrac_pkg::job_t   q [2];
  logic              wr_ptr;
  logic              rd_ptr;
  logic [1:0]        fill;

  // true when the top bytes of addr equal the own prefix
  function automatic logic own_match(input logic [47:0] addr, input logic [47:0] prefix,
                                     input logic [2:0] len);
    logic [47:0] mask;
    logic [2:0]  n;
    n    = (len > 3'd6) ? 3'd6 : len;
    mask = '0;
    for (int b = 0; b < 6; b++) begin
      if (3'(b) < n) mask[47 - 8 * b -: 8] = 8'hFF;
    end
    return (n != 3'd0) && ((addr & mask) == (prefix & mask));
  endfunction

  assign fcl   = s_tdata[7:0];
  assign fch   = s_tdata[15:8];
  assign a1    = s_tdata[63:16];
  assign a2    = s_tdata[111:64];
  assign ftype = fcl[3:2];
  assign fsub  = fcl[7:4];

  // classify by DS bits and management subtype
  always_comb begin
    item.is_tick = s_tuser;
    item.sig     = s_tdata[167:160];
    item.station = a2;
    item.dir     = wsrac_pkg::DIR_FROM_STA;
    classed      = 1'b0;
    if (fch[0] && fch[1]) begin
      classed = 1'b0;
    end else if (fch[0]) begin
      classed = 1'b1;
    end else if (fch[1]) begin
      item.station = a1;
      item.dir     = wsrac_pkg::DIR_TO_STA;
      classed      = 1'b1;
    end else if (ftype == wsrac_pkg::TYPE_MGMT && fsub == wsrac_pkg::SUB_PROBE_REQ) begin
      classed = 1'b1;
    end else if (ftype == wsrac_pkg::TYPE_MGMT && fsub == wsrac_pkg::SUB_PROBE_RESP) begin
      item.station = a1;
      item.dir     = wsrac_pkg::DIR_TO_STA;
      classed      = 1'b1;
    end
    keep = classed
         && !own_match(item.station, cfg.own_prefix, cfg.own_prefix_len)
         && !(cfg.filt_bcast && item.station == 48'hFFFF_FFFF_FFFF);
  end

  // two-entry queue toward the back end; dropped frames are never queued
  assign s_tready  = (fill != 2'd2);
  assign push      = s_tvalid && s_tready && (s_tuser || keep);
  assign job_valid = (fill != 2'd0);
  assign pop       = job_valid && job_ready;
  assign job       = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) q[wr_ptr] <= item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      fill <= fill + 2'(push) - 2'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    fill == 2'd2 |-> !push) else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    fill == 2'd0 |-> !pop) else $error("queue underflow");
  a_fill_step: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> fill == $past(fill) + 2'd1) else $error("fill count slip");

endmodule

[sv/wsrac_div.sv]
`timescale 1ns / 1ps
module wsrac_div (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [23:0] dividend,
  input  logic [15:0]        divisor,
  output logic               done,
  output logic [7:0]         quot
);

  logic        busy;
  logic [4:0]  cnt;
  logic [15:0] rem;
  logic [23:0] dvd;
  logic [15:0] dsr;
  logic [7:0]  q;
  logic        neg;
  logic [16:0] trial;
  logic        fits;

  // restoring division on magnitudes, one quotient bit a cycle; the average
  // magnitude never exceeds 128, so the low quotient byte is all that is kept
  assign trial = {rem, dvd[23]};
  assign fits  = trial >= {1'b0, dsr};
  assign quot  = neg ? 8'(-q) : q;

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend[23] ? 24'(-dividend) : dividend;
      dsr <= divisor;
      rem <= '0;
      q   <= '0;
      neg <= dividend[23];
    end else if (busy) begin
      rem <= fits ? 16'(trial - {1'b0, dsr}) : trial[15:0];
      dvd <= {dvd[22:0], 1'b0};
      q   <= {q[6:0], fits};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 5'd24;
      end else if (busy) begin
        cnt <= cnt - 5'd1;
        if (cnt == 5'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy)) else $error("done without work");
  a_no_restart: assert property (@(posedge clk) disable iff (rst)
    busy |-> !start) else $error("divider restarted while busy");
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("divider busy after done");

endmodule

[sv/wsrac_back.sv]
`timescale 1ns / 1ps
module wsrac_back (
  input  logic                clk,
  input  logic                rst,
  input  wsrac_pkg::cfg_t     cfg,
  input  logic                job_valid,
  output logic                job_ready,
  input  wsrac_pkg::job_t     job,
  output logic                m_valid,
  input  logic                m_ready,
  output wsrac_pkg::report_t  m_rep,
  output logic                m_last
);

  localparam logic [wsrac_pkg::IDX_W-1:0] LAST_IDX = wsrac_pkg::IDX_W'(wsrac_pkg::ENTRIES - 1);
  localparam logic [wsrac_pkg::IDX_W-1:0] IDX_ONE  = wsrac_pkg::IDX_W'(1);

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_SCAN   = 9'b000000010,
    S_DIV    = 9'b000000100,
    S_EMIT   = 9'b000001000,
    S_DECIDE = 9'b000010000,
    S_EVICT  = 9'b000100000,
    S_INSERT = 9'b001000000,
    S_UPDATE = 9'b010000000,
    S_FLUSH  = 9'b100000000
  } state_t;

  state_t state;

  // table storage
  logic [47:0]        tbl_station [wsrac_pkg::ENTRIES];
  logic [1:0]         tbl_dir     [wsrac_pkg::ENTRIES];
  logic [31:0]        tbl_ins     [wsrac_pkg::ENTRIES];
  logic signed [7:0]  tbl_low     [wsrac_pkg::ENTRIES];
  logic signed [7:0]  tbl_high    [wsrac_pkg::ENTRIES];
  logic signed [23:0] tbl_sum     [wsrac_pkg::ENTRIES];
  logic [15:0]        tbl_hits    [wsrac_pkg::ENTRIES];

  logic [31:0]                   now_ms;
  logic [wsrac_pkg::IDX_W-1:0]   idx;
  logic [wsrac_pkg::IDX_W-1:0]   pick;
  logic [wsrac_pkg::IDX_W-1:0]   midx;
  logic                          have_free;
  logic                          hit_found;
  logic [31:0]                   best_age;
  logic                          evicting;
  wsrac_pkg::job_t               cur;
  wsrac_pkg::report_t            cap;
  wsrac_pkg::report_t            pend;
  logic                          pvalid;

  logic [31:0]        age;
  logic               used;
  logic               aged;
  logic               key_hit;
  logic               out_free;
  logic               m_load;
  logic               div_start;
  logic               div_done;
  logic [7:0]         div_q;
  wsrac_pkg::report_t rep;
  logic signed [23:0] sig_ext;

  assign age      = now_ms - tbl_ins[idx];
  assign used     = tbl_hits[idx] != 16'd0;
  assign aged     = used && (age > cfg.max_age);
  assign key_hit  = used && tbl_station[idx] == cur.station && tbl_dir[idx] == cur.dir;
  assign out_free = !m_valid || m_ready;
  assign m_load   = pvalid && out_free && (state == S_EMIT || state == S_FLUSH);
  assign sig_ext  = 24'(cur.sig);
  assign job_ready = (state == S_IDLE);
  assign div_start = ((state == S_SCAN) && aged) || ((state == S_EVICT) && used);

  always_comb begin
    rep     = cap;
    rep.avg = div_q;
  end

  wsrac_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (tbl_sum[idx]),
    .divisor  (tbl_hits[idx]),
    .done     (div_done),
    .quot     (div_q)
  );

  // entry payload, written on insert and update
  always_ff @(posedge clk) begin
    if (state == S_INSERT) begin
      tbl_station[idx] <= cur.station;
      tbl_dir[idx]     <= cur.dir;
      tbl_ins[idx]     <= now_ms;
      tbl_low[idx]     <= cur.sig;
      tbl_high[idx]    <= cur.sig;
      tbl_sum[idx]     <= sig_ext;
    end else if (state == S_UPDATE) begin
      if (tbl_hits[idx] < wsrac_pkg::HITS_MAX) tbl_sum[idx] <= tbl_sum[idx] + sig_ext;
      if (cur.sig < tbl_low[idx])  tbl_low[idx]  <= cur.sig;
      if (cur.sig > tbl_high[idx]) tbl_high[idx] <= cur.sig;
    end
  end

  // report capture at eviction, and the latch of the accepted job
  always_ff @(posedge clk) begin
    if (div_start) begin
      cap.station <= tbl_station[idx];
      cap.dir     <= tbl_dir[idx];
      cap.age     <= age;
      cap.count   <= tbl_hits[idx];
      cap.low     <= tbl_low[idx];
      cap.high    <= tbl_high[idx];
      cap.avg     <= '0;
    end
    if (state == S_IDLE && job_valid) cur <= job;
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      now_ms    <= '0;
      idx       <= '0;
      pick      <= '0;
      midx      <= '0;
      have_free <= 1'b0;
      hit_found <= 1'b0;
      best_age  <= '0;
      evicting  <= 1'b0;
      pvalid    <= 1'b0;
      m_valid   <= 1'b0;
      m_last    <= 1'b0;
      for (int i = 0; i < wsrac_pkg::ENTRIES; i++) tbl_hits[i] <= '0;
    end else begin
      if (m_load) begin
        m_valid <= 1'b1;
      end else if (m_valid && m_ready) begin
        m_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (job_valid) begin
            if (job.is_tick) begin
              now_ms <= now_ms + 32'(cfg.tick_step);
            end else begin
              idx       <= '0;
              pick      <= '0;
              have_free <= 1'b0;
              hit_found <= 1'b0;
              best_age  <= '0;
              evicting  <= 1'b0;
              state     <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (!used) begin
            have_free <= 1'b1;
            pick      <= idx;
          end else if (aged) begin
            have_free     <= 1'b1;
            pick          <= idx;
            tbl_hits[idx] <= '0;
          end else begin
            if (!have_free && (idx == '0 || age > best_age)) begin
              best_age <= age;
              pick     <= idx;
            end
            if (key_hit) begin
              hit_found <= 1'b1;
              midx      <= idx;
            end
          end
          if (aged) begin
            state <= S_DIV;
          end else if (idx == LAST_IDX) begin
            state <= S_DECIDE;
          end else begin
            idx <= idx + IDX_ONE;
          end
        end
        S_DIV: begin
          if (div_done) state <= S_EMIT;
        end
        S_EMIT: begin
          // hold the newest report back until we know whether it is the last
          if (!pvalid || out_free) begin
            if (pvalid) begin
              m_rep  <= pend;
              m_last <= 1'b0;
            end
            pend   <= rep;
            pvalid <= 1'b1;
            if (evicting) begin
              state <= S_INSERT;
            end else if (idx == LAST_IDX) begin
              state <= S_DECIDE;
            end else begin
              idx   <= idx + IDX_ONE;
              state <= S_SCAN;
            end
          end
        end
        S_DECIDE: begin
          idx   <= hit_found ? midx : pick;
          state <= hit_found ? S_UPDATE : S_EVICT;
        end
        S_EVICT: begin
          if (used) begin
            tbl_hits[idx] <= '0;
            evicting      <= 1'b1;
            state         <= S_DIV;
          end else begin
            state <= S_INSERT;
          end
        end
        S_INSERT: begin
          tbl_hits[idx] <= 16'd1;
          state         <= S_FLUSH;
        end
        S_UPDATE: begin
          if (tbl_hits[idx] < wsrac_pkg::HITS_MAX) tbl_hits[idx] <= tbl_hits[idx] + 16'd1;
          state <= S_FLUSH;
        end
        S_FLUSH: begin
          if (!pvalid) begin
            state <= S_IDLE;
          end else if (out_free) begin
            m_rep   <= pend;
            m_last  <= 1'b1;
            pvalid  <= 1'b0;
            state   <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_idle_no_pending: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !pvalid) else $error("report left pending between items");
  a_div_to_emit: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV && div_done) |=> state == S_EMIT) else $error("division result lost");
  a_insert_sets_hits: assert property (@(posedge clk) disable iff (rst)
    state == S_INSERT |=> tbl_hits[$past(idx)] == 16'd1) else $error("insert did not land");
  a_evict_reports: assert property (@(posedge clk) disable iff (rst)
    (state == S_EVICT && used) |=> state == S_DIV) else $error("oldest entry not reported");

endmodule

[verif/wsrac_station_checker.sv]
`timescale 1ns / 1ps
module wsrac_station_checker (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [167:0] s_tdata,
  input  logic         s_tuser,
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [127:0] m_tdata,
  input  logic         m_tlast,
  input  logic         cfg_valid,
  input  logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [47:0]  cfg_data,
  output int           errors,
  output int           pending,
  output int           reports_seen
);

  typedef struct {
    wsrac_pkg::report_t r;
    logic               fin;
  } evict_note_t;

  // shadow copy of the registers
  logic [31:0] age_limit;
  logic [15:0] step_ms;
  logic        drop_bcast;
  logic [47:0] prefix;
  logic [2:0]  prefix_len;

  // shadow copy of the table
  logic [31:0] clock_ms;
  logic [47:0] slot_sta [wsrac_pkg::ENTRIES];
  logic [1:0]  slot_dir [wsrac_pkg::ENTRIES];
  logic [31:0] slot_born [wsrac_pkg::ENTRIES];
  int          slot_lo [wsrac_pkg::ENTRIES];
  int          slot_hi [wsrac_pkg::ENTRIES];
  int          slot_sum [wsrac_pkg::ENTRIES];
  int          slot_hits [wsrac_pkg::ENTRIES];

  evict_note_t evictions [$];

  assign pending = evictions.size();

  task automatic wipe_slot(int i);
    slot_sta[i] = '0;
    slot_dir[i] = '0;
    slot_born[i] = '0;
    slot_lo[i] = 0;
    slot_hi[i] = 0;
    slot_sum[i] = 0;
    slot_hits[i] = 0;
  endtask

  // queue the report of one slot and free it
  task automatic evict_slot(int i);
    evict_note_t e;
    int avg;
    avg = slot_sum[i] / slot_hits[i];
    e.r.station = slot_sta[i];
    e.r.dir = slot_dir[i];
    e.r.age = clock_ms - slot_born[i];
    e.r.count = slot_hits[i][15:0];
    e.r.low = slot_lo[i][7:0];
    e.r.high = slot_hi[i][7:0];
    e.r.avg = avg[7:0];
    e.fin = 1'b0;
    evictions.push_back(e);
    wipe_slot(i);
  endtask

  // fold one accepted input transaction into the shadow table
  task automatic fold_item(logic [167:0] d, logic tick);
    logic [7:0]  fcl;
    logic [7:0]  fch;
    logic [47:0] sta;
    logic [1:0]  dir;
    int          sig;
    int          shift;
    int          n0;
    int          pick;
    logic        have_free;
    logic        matched;
    logic [31:0] best_age;
    logic [31:0] age;
    fcl = d[7:0];
    fch = d[15:8];
    sig = $signed(d[167:160]);
    pick = 0;
    have_free = 1'b0;
    matched = 1'b0;
    best_age = '0;
    if (tick) begin
      clock_ms = clock_ms + 32'(step_ms);
      return;
    end
    // classification by the DS bits, then by management subtype
    if (fch[0] && fch[1]) return;
    if (fch[0]) begin
      sta = d[111:64];
      dir = wsrac_pkg::DIR_FROM_STA;
    end else if (fch[1]) begin
      sta = d[63:16];
      dir = wsrac_pkg::DIR_TO_STA;
    end else if (fcl[3:2] == wsrac_pkg::TYPE_MGMT && fcl[7:4] == wsrac_pkg::SUB_PROBE_REQ) begin
      sta = d[111:64];
      dir = wsrac_pkg::DIR_FROM_STA;
    end else if (fcl[3:2] == wsrac_pkg::TYPE_MGMT && fcl[7:4] == wsrac_pkg::SUB_PROBE_RESP) begin
      sta = d[63:16];
      dir = wsrac_pkg::DIR_TO_STA;
    end else begin
      return;
    end
    // own-device prefix and broadcast filters
    if (prefix_len != 3'd0) begin
      shift = 8 * (6 - ((prefix_len > 3'd6) ? 6 : int'(prefix_len)));
      if ((sta >> shift) == (prefix >> shift)) return;
    end
    if (drop_bcast && sta == 48'hFFFF_FFFF_FFFF) return;
    n0 = evictions.size();
    // aging walk, also picks the victim slot
    for (int i = 0; i < wsrac_pkg::ENTRIES; i++) begin
      if (slot_hits[i] == 0) begin
        have_free = 1'b1;
        pick = i;
        continue;
      end
      age = clock_ms - slot_born[i];
      if (age > age_limit) begin
        evict_slot(i);
        have_free = 1'b1;
        pick = i;
        continue;
      end
      if (!have_free && (i == 0 || age > best_age)) begin
        best_age = age;
        pick = i;
      end
    end
    for (int i = 0; i < wsrac_pkg::ENTRIES && !matched; i++) begin
      if (slot_hits[i] != 0 && slot_sta[i] == sta && slot_dir[i] == dir) begin
        matched = 1'b1;
        // count and sum freeze at saturation
        if (slot_hits[i] < 65535) begin
          slot_sum[i] += sig;
          slot_hits[i]++;
        end
        if (sig < slot_lo[i]) slot_lo[i] = sig;
        if (sig > slot_hi[i]) slot_hi[i] = sig;
      end
    end
    if (!matched) begin
      if (slot_hits[pick] != 0) evict_slot(pick);
      slot_sta[pick] = sta;
      slot_dir[pick] = dir;
      slot_born[pick] = clock_ms;
      slot_lo[pick] = sig;
      slot_hi[pick] = sig;
      slot_sum[pick] = sig;
      slot_hits[pick] = 1;
    end
    if (evictions.size() > n0) evictions[evictions.size() - 1].fin = 1'b1;
  endtask

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    errors++;
    $display("[%0t] report %0d: %s got %0h want %0h", $realtime, reports_seen, what, got,
             want);
  endtask

  // compare one output transaction with the oldest expectation
  task automatic check_report();
    wsrac_pkg::report_t got;
    evict_note_t        e;
    got = m_tdata[121:0];
    if (evictions.size() == 0) begin
      report("unexpected station_addr", 64'(got.station), '0);
      return;
    end
    e = evictions.pop_front();
    if (got.station !== e.r.station)
      report("station_addr", 64'(got.station), 64'(e.r.station));
    if (got.dir !== e.r.dir) report("direction", 64'(got.dir), 64'(e.r.dir));
    if (got.age !== e.r.age) report("age_ms", 64'(got.age), 64'(e.r.age));
    if (got.count !== e.r.count) report("frame_count", 64'(got.count), 64'(e.r.count));
    if (got.low !== e.r.low) report("signal_min", 64'(got.low), 64'(e.r.low));
    if (got.high !== e.r.high) report("signal_max", 64'(got.high), 64'(e.r.high));
    if (got.avg !== e.r.avg) report("signal_avg", 64'(got.avg), 64'(e.r.avg));
    if (m_tlast !== e.fin) report("last", 64'(m_tlast), 64'(e.fin));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      errors = 0;
      reports_seen = 0;
      age_limit <= 32'd10000;
      step_ms <= 16'd100;
      drop_bcast <= 1'b1;
      prefix <= '0;
      prefix_len <= '0;
      clock_ms = '0;
      for (int i = 0; i < wsrac_pkg::ENTRIES; i++) wipe_slot(i);
      evictions.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          wsrac_pkg::CFG_MAX_AGE:    age_limit <= cfg_data[31:0];
          wsrac_pkg::CFG_TICK_STEP:  step_ms <= cfg_data[15:0];
          wsrac_pkg::CFG_FILT_BCAST: drop_bcast <= cfg_data[0];
          wsrac_pkg::CFG_OWN_PREFIX: prefix <= cfg_data;
          wsrac_pkg::CFG_PREFIX_LEN: prefix_len <= cfg_data[2:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) fold_item(s_tdata, s_tuser);
      if (m_tvalid && m_tready) begin
        check_report();
        reports_seen++;
      end
    end
  end

endmodule

[verif/tb_wifi_station_rssi_aggregation_cache.sv]
`timescale 1ns / 1ps
module tb_wifi_station_rssi_aggregation_cache;

  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int SETTLE = 150;

  typedef enum int {K_UP, K_DOWN, K_PROBE_REQ, K_PROBE_RESP, K_BOTH_DS, K_NOISE} frame_kind_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [167:0] s_tdata = '0;   // fcl, fch, address_one, address_two, address_three, signal
  logic         s_tuser = 1'b0; // opcode
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [127:0] m_tdata;        // station, dir, age, count, min, max, avg, pad
  logic         m_tlast;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [2:0]   cfg_index = '0;
  logic [47:0]  cfg_data = '0;

  int errors, pending, reports_seen;
  int cycles = 0;
  int frames_sent = 0, ticks_sent = 0, cfg_writes = 0;
  logic send_burst = 1'b0;
  logic [47:0] pool [20];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  wifi_station_rssi_aggregation_cache dut (.*);

  wsrac_station_checker chk (.*);

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // result sink with random stalls and stall-free stretches
  initial begin
    int stall;
    int taken;
    taken = 0;
    forever begin
      stall = ((taken / 30) % 3 == 2) ? 0 : $urandom_range(0, 14);
      @(negedge clk);
      m_tready = 1'b0;
      repeat (stall) @(negedge clk);
      m_tready = 1'b1;
      do @(posedge clk); while (!m_tvalid || rst);
      taken++;
    end
  end

  task automatic send_item(logic op, logic [167:0] d);
    int gap;
    gap = send_burst ? 0 : $urandom_range(0, 14);
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tuser = op;
    s_tdata = d;
    do @(posedge clk); while (!s_tready);
    if (op) ticks_sent++;
    else frames_sent++;
  endtask

  task automatic end_input();
    @(negedge clk);
    s_tvalid = 1'b0;
  endtask

  task automatic write_reg(logic [2:0] idx, logic [47:0] val);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
    cfg_writes++;
  endtask

  // drain every expected report, then let a dropped frame in flight finish
  task automatic drain();
    end_input();
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_regs(logic [31:0] age, logic [15:0] step, logic fb, logic [47:0] pfx,
                          logic [2:0] plen);
    write_reg(wsrac_pkg::CFG_MAX_AGE, {16'h0, age});
    write_reg(wsrac_pkg::CFG_TICK_STEP, {32'h0, step});
    write_reg(wsrac_pkg::CFG_FILT_BCAST, {47'h0, fb});
    write_reg(wsrac_pkg::CFG_OWN_PREFIX, pfx);
    write_reg(wsrac_pkg::CFG_PREFIX_LEN, {45'h0, plen});
  endtask

  function automatic logic [167:0] make_frame(frame_kind_t k, logic [47:0] sta,
                                               logic [7:0] sig);
    logic [7:0]  fcl;
    logic [7:0]  fch;
    logic [47:0] a1;
    logic [47:0] a2;
    logic [47:0] a3;
    fcl = 8'($urandom);
    fch = 8'($urandom);
    a1 = 48'({$urandom, $urandom});
    a2 = 48'({$urandom, $urandom});
    a3 = 48'({$urandom, $urandom});
    case (k)
      K_UP:      begin fch[1:0] = 2'b01; a2 = sta; end
      K_DOWN:    begin fch[1:0] = 2'b10; a1 = sta; end
      K_PROBE_REQ: begin
        fch[1:0] = 2'b00; fcl[7:4] = wsrac_pkg::SUB_PROBE_REQ;
        fcl[3:2] = wsrac_pkg::TYPE_MGMT; a2 = sta;
      end
      K_PROBE_RESP: begin
        fch[1:0] = 2'b00; fcl[7:4] = wsrac_pkg::SUB_PROBE_RESP;
        fcl[3:2] = wsrac_pkg::TYPE_MGMT; a1 = sta;
      end
      K_BOTH_DS: fch[1:0] = 2'b11;
      default: ;
    endcase
    return {sig, a3, a2, a1, fch, fcl};
  endfunction

  function automatic logic [47:0] pick_station();
    if ($urandom_range(0, 7) == 0) return 48'({$urandom, $urandom});
    return pool[$urandom_range(0, 19)];
  endfunction

  task automatic random_phase(int n);
    frame_kind_t k;
    for (int i = 0; i < n; i++) begin
      if (i % 40 == 0) send_burst = ($urandom_range(0, 2) == 0);
      if (i == n / 2 && $urandom_range(0, 1)) begin
        end_input();
        while (pending != 0) @(posedge clk);
      end
      if ($urandom_range(0, 6) == 0) begin
        send_item(1'b1, 168'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom}));
      end else begin
        k = frame_kind_t'($urandom_range(0, 9) < 8 ? $urandom_range(0, 3)
                                                    : $urandom_range(4, 5));
        send_item(1'b0, make_frame(k, pick_station(), 8'($urandom)));
      end
    end
    drain();
  endtask

  initial begin
    for (int i = 0; i < 18; i++) pool[i] = {(i % 2) ? 8'h0A : 8'h02, 32'h0, 8'(i)};
    pool[18] = '0;
    pool[19] = '1;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: every class, signal extremes, the broadcast filter, running stats
    send_item(1'b1, '0);
    send_item(1'b0, make_frame(K_UP, pool[0], 8'h80));
    send_item(1'b0, make_frame(K_UP, pool[0], 8'h7F));
    send_item(1'b0, make_frame(K_UP, pool[0], 8'hFD));
    send_item(1'b0, make_frame(K_DOWN, pool[0], 8'hFC));
    send_item(1'b0, make_frame(K_DOWN, pool[0], 8'hFD));
    send_item(1'b0, make_frame(K_PROBE_REQ, pool[1], 8'h00));
    send_item(1'b0, make_frame(K_PROBE_RESP, pool[18], 8'hC0));
    send_item(1'b0, make_frame(K_BOTH_DS, pool[2], 8'h10));
    send_item(1'b0, make_frame(K_NOISE, pool[2], 8'h10));
    send_item(1'b0, make_frame(K_UP, pool[19], 8'h20));
    // more stations than slots: the oldest is pushed out
    for (int i = 2; i < 18; i++) begin
      send_item(1'b1, '0);
      send_item(1'b0, make_frame(frame_kind_t'(i % 4), pool[i], 8'(i * 13)));
    end
    drain();

    // aging several entries at once
    set_regs(32'd250, 16'd100, 1'b0, 48'h0, 3'd0);
    for (int i = 0; i < 4; i++) send_item(1'b1, '0);
    send_item(1'b0, make_frame(K_UP, pool[19], 8'h55));
    drain();

    random_phase(70);
    set_regs(32'd0, 16'd1, 1'b0, 48'h02_00_00_00_00_00, 3'd1);
    random_phase(60);
    set_regs(32'hFFFF_FFFF, 16'hFFFF, 1'b1, 48'({$urandom, $urandom}), 3'd7);
    random_phase(60);
    set_regs(32'd300, 16'd100, 1'b0, 48'h0A_00_00_00_00_05, 3'd6);
    random_phase(60);
    set_regs(32'd1500, 16'd250, 1'b1, 48'h02_00_00_00_00_00, 3'd3);
    random_phase(60);
    set_regs($urandom_range(200, 5000), 16'd1, 1'b0, 48'h0A_00_00_00_00_00, 3'd4);
    random_phase(60);

    $display("Covered %0d frames and %0d ticks over %0d register writes,", frames_sent,
             ticks_sent, cfg_writes);
    $display("with %0d evicted-entry reports checked.", reports_seen);
    if (errors == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
